/* hdl/fvc_pkg.sv */
// Shared types and constants for the flywheel velocity controller.
`timescale 1ns / 1ps

package fvc_pkg;

    // Request codes
    localparam logic [1:0] ReqFixed    = 2'd0;
    localparam logic [1:0] ReqDistance = 2'd1;
    localparam logic [1:0] ReqStop     = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] RegKpGain       = 3'd0;
    localparam logic [2:0] RegTargetSpeed  = 3'd1;
    localparam logic [2:0] RegFfSlope      = 3'd2;
    localparam logic [2:0] RegFfOffset     = 3'd3;
    localparam logic [2:0] RegOutputLimit  = 3'd4;
    localparam logic [2:0] RegSlewStep     = 3'd5;
    localparam logic [2:0] RegBandFixed    = 3'd6;
    localparam logic [2:0] RegBandDistance = 3'd7;

    // Register reset values
    localparam logic [15:0] KpGainReset       = 16'd1174;
    localparam logic [14:0] TargetSpeedReset  = 15'd3000;
    localparam logic [15:0] FfSlopeReset      = 16'd1510;
    localparam logic [15:0] FfOffsetReset     = 16'd236;
    localparam logic [14:0] OutputLimitReset  = 15'd32440;
    localparam logic [14:0] SlewStepReset     = 15'd9830;
    localparam logic [15:0] BandFixedReset    = 16'd250;
    localparam logic [15:0] BandDistanceReset = 16'd150;

    // Distance target line in Q8 rpm: 13.1389*d + 3269.23
    localparam logic signed [16:0] DistSlopeQ8  = 17'sd3364;
    localparam logic signed [30:0] DistOffsetQ8 = 31'sd836923;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_TGT,
        S_ERR,
        S_KPL,
        S_KPH,
        S_FFL,
        S_FFH,
        S_CLAMP,
        S_SLEW,
        S_DONE
    } t_state;

endpackage

/* hdl/flywheel_velocity_controller_top.sv */
// Flywheel velocity controller: sequencer around one shared multiplier.
`timescale 1ns / 1ps

// Proportional speed control with linear feedforward, absolute clamp and
// slew limit. A run request steps through TGT (distance-target multiply),
// ERR, KPL and KPH (two partial products for the gain term), FFL and FFH
// (two for the feedforward term), CLAMP, SLEW and DONE, all on a single
// 17 x 14 bit multiplier; a stop request goes straight to DONE. The input
// is stalled while an item is in flight. One result register sits on the
// output, so an item may be accepted while a result still waits there.
// Configuration writes are always taken; write only while idle.
module flywheel_velocity_controller_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_req_type,
    input  logic signed [15:0] i_measured_rpm,
    input  logic [9:0]         i_distance_in,
    input  logic signed [4:0]  i_trim_steps,
    // output channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [15:0] o_drive,
    output logic               o_at_speed,
    // configuration channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    import fvc_pkg::*;

    // configuration registers
    logic [15:0]        r_kp_gain;
    logic [14:0]        r_target_speed;
    logic [15:0]        r_ff_slope;
    logic signed [15:0] r_ff_offset;
    logic [14:0]        r_output_limit;
    logic [14:0]        r_slew_step;
    logic [15:0]        r_band_fixed;
    logic [15:0]        r_band_distance;

    // sequencer and item registers
    t_state             r_state, n_state;
    logic               r_req_dist;
    logic signed [15:0] r_meas;
    logic signed [11:0] r_dist;
    logic [22:0]        r_tgt;
    logic signed [25:0] r_err;
    logic               r_at;
    logic signed [42:0] r_acc;
    logic signed [27:0] r_drive;
    logic signed [15:0] r_last;

    // output register
    logic               r_out_valid;
    logic signed [15:0] r_out_drive;
    logic               r_out_at;

    // shared multiplier
    logic signed [16:0] mul_a;
    logic signed [13:0] mul_b;
    logic signed [30:0] mul_p;
    logic signed [42:0] acc_sum;

    logic               in_xfer;
    logic               out_free;
    logic               out_load;
    logic signed [11:0] dist_next;
    logic signed [25:0] err_next;
    logic [25:0]        abs_err;
    logic [15:0]        band_sel;
    logic signed [16:0] delta;
    logic signed [16:0] slew_pos;
    logic signed [16:0] slew_neg;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_xfer     = i_in_valid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;

    // take configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp_gain       <= KpGainReset;
            r_target_speed  <= TargetSpeedReset;
            r_ff_slope      <= FfSlopeReset;
            r_ff_offset     <= FfOffsetReset;
            r_output_limit  <= OutputLimitReset;
            r_slew_step     <= SlewStepReset;
            r_band_fixed    <= BandFixedReset;
            r_band_distance <= BandDistanceReset;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                RegKpGain:       r_kp_gain       <= i_cfg_data;
                RegTargetSpeed:  r_target_speed  <= i_cfg_data[14:0];
                RegFfSlope:      r_ff_slope      <= i_cfg_data;
                RegFfOffset:     r_ff_offset     <= i_cfg_data;
                RegOutputLimit:  r_output_limit  <= i_cfg_data[14:0];
                RegSlewStep:     r_slew_step     <= i_cfg_data[14:0];
                RegBandFixed:    r_band_fixed    <= i_cfg_data;
                RegBandDistance: r_band_distance <= i_cfg_data;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (i_req_type == ReqFixed || i_req_type == ReqDistance) begin
                        n_state = S_TGT;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_TGT:   n_state = S_ERR;
            S_ERR:   n_state = S_KPL;
            S_KPL:   n_state = S_KPH;
            S_KPH:   n_state = S_FFL;
            S_FFL:   n_state = S_FFH;
            S_FFH:   n_state = S_CLAMP;
            S_CLAMP: n_state = S_SLEW;
            S_SLEW:  n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    // multiplier operand select and result hand-off
    always_comb begin
        mul_a    = 17'sd0;
        mul_b    = 14'sd0;
        out_load = 1'b0;
        unique case (r_state)
            S_TGT: begin
                mul_a = DistSlopeQ8;
                mul_b = 14'(r_dist);
            end
            S_KPL: begin
                mul_a = $signed({1'b0, r_kp_gain});
                mul_b = $signed({1'b0, r_err[12:0]});
            end
            S_KPH: begin
                mul_a = $signed({1'b0, r_kp_gain});
                mul_b = 14'($signed(r_err[25:13]));
            end
            S_FFL: begin
                mul_a = $signed({1'b0, r_ff_slope});
                mul_b = $signed({1'b0, r_tgt[12:0]});
            end
            S_FFH: begin
                mul_a = $signed({1'b0, r_ff_slope});
                mul_b = $signed({4'b0, r_tgt[22:13]});
            end
            S_DONE:  out_load = out_free;
            default: ;
        endcase
    end

    assign mul_p   = mul_a * mul_b;
    assign acc_sum = r_acc + (43'(mul_p) <<< 13);

    // distance with trim: d = distance + 6 * trim
    assign dist_next = $signed({2'b0, i_distance_in})
                     + (12'(i_trim_steps) <<< 2) + (12'(i_trim_steps) <<< 1);

    // speed error against twice the measured speed, Q8
    assign err_next = $signed({3'b0, r_tgt})
                    - 26'($signed({r_meas, 9'b0}));
    assign abs_err  = err_next[25] ? 26'(-err_next) : 26'(err_next);
    assign band_sel = r_req_dist ? r_band_distance : r_band_fixed;

    // slew limit against the previous drive
    assign delta    = 17'($signed(r_drive[15:0])) - 17'(r_last);
    assign slew_pos = 17'(r_last) + $signed({2'b0, r_slew_step});
    assign slew_neg = 17'(r_last) - $signed({2'b0, r_slew_step});

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    r_req_dist <= (i_req_type == ReqDistance);
                    r_meas     <= i_measured_rpm;
                    r_dist     <= dist_next;
                    r_drive    <= 28'sd0;
                    r_at       <= 1'b0;
                end
            end
            S_TGT: begin
                if (r_req_dist) begin
                    r_tgt <= 23'(mul_p + DistOffsetQ8);
                end else begin
                    r_tgt <= {r_target_speed, 8'b0};
                end
            end
            S_ERR: begin
                r_err <= err_next;
                r_at  <= (abs_err < {2'b0, band_sel, 8'b0});
            end
            S_KPL: r_acc <= 43'(mul_p);
            S_KPH: r_drive <= 28'($signed(acc_sum[42:17]));
            S_FFL: r_acc <= 43'(mul_p);
            S_FFH: r_drive <= r_drive + 28'($signed(acc_sum[42:17])) + 28'(r_ff_offset);
            S_CLAMP: begin
                if (r_drive > $signed({13'b0, r_output_limit})) begin
                    r_drive <= $signed({13'b0, r_output_limit});
                end else if (r_drive < -$signed({13'b0, r_output_limit})) begin
                    r_drive <= -$signed({13'b0, r_output_limit});
                end
            end
            S_SLEW: begin
                if (delta > $signed({2'b0, r_slew_step})) begin
                    r_drive <= 28'(slew_pos);
                end else if (delta < -$signed({2'b0, r_slew_step})) begin
                    r_drive <= 28'(slew_neg);
                end
            end
            S_DONE: ;
        endcase
    end

    // drive history, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= 16'sd0;
        end else if (out_load) begin
            r_last <= r_drive[15:0];
        end
    end

    // output register: load on hand-off, drop on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_drive <= r_drive[15:0];
            r_out_at    <= r_at;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_drive     = r_out_drive;
    assign o_at_speed  = r_out_at;

endmodule

/* verif/tb.sv */
// Self-checking testbench for the flywheel velocity controller top level.
`timescale 1ns / 1ps

module tb;
    import fvc_pkg::*;

    // Request code that the block treats as a stop
    localparam logic [1:0] ReqUnused = 2'd3;
    localparam int TrimInches = 6;
    localparam int GainShift = 17;
    localparam int QuietLimit = 4000;
    localparam int SettleCycles = 24;

    typedef struct packed {
        logic signed [15:0] drive;
        logic               at_speed;
    } t_drive_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [1:0]         i_req_type;
    logic signed [15:0] i_measured_rpm;
    logic [9:0]         i_distance_in;
    logic signed [4:0]  i_trim_steps;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic signed [15:0] o_drive;
    logic               o_at_speed;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index;
    logic [15:0]        i_cfg_data;

    // Controller settings and drive history as the block should hold them
    logic [15:0]        kp_q24;
    logic [14:0]        target_rpm;
    logic [15:0]        slope_q24;
    logic signed [15:0] offset_q15;
    logic [14:0]        limit_q15;
    logic [14:0]        slew_q15;
    logic [15:0]        band_fixed_rpm;
    logic [15:0]        band_dist_rpm;
    logic signed [15:0] held_drive;

    t_drive_result pending_drives[$];
    t_drive_result oldest_drive;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatches = 0;
    int items_sent = 0;
    int results_checked = 0;
    int at_speed_hits = 0;
    int reg_writes = 0;
    int quiet_cycles = 0;

    flywheel_velocity_controller_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_measured_rpm (i_measured_rpm),
        .i_distance_in  (i_distance_in),
        .i_trim_steps   (i_trim_steps),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_drive        (o_drive),
        .o_at_speed     (o_at_speed),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Stall the result channel at random
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    function automatic void load_reset_settings();
        kp_q24         = KpGainReset;
        target_rpm     = TargetSpeedReset;
        slope_q24      = FfSlopeReset;
        offset_q15     = FfOffsetReset;
        limit_q15      = OutputLimitReset;
        slew_q15       = SlewStepReset;
        band_fixed_rpm = BandFixedReset;
        band_dist_rpm  = BandDistanceReset;
        held_drive     = '0;
    endfunction

    function automatic void apply_setting(input logic [2:0] index, input logic [15:0] data);
        case (index)
            RegKpGain:       kp_q24 = data;
            RegTargetSpeed:  target_rpm = data[14:0];
            RegFfSlope:      slope_q24 = data;
            RegFfOffset:     offset_q15 = data;
            RegOutputLimit:  limit_q15 = data[14:0];
            RegSlewStep:     slew_q15 = data[14:0];
            RegBandFixed:    band_fixed_rpm = data;
            RegBandDistance: band_dist_rpm = data;
        endcase
    endfunction

    // Work out the drive for one request and advance the drive history
    function automatic t_drive_result predict_drive(input logic [1:0] req,
                                                    input logic signed [15:0] meas,
                                                    input logic [9:0] dist_in,
                                                    input logic signed [4:0] trim);
        longint target_q8, err_q8, abs_err, band_q8, inches, drv, lim, step;
        t_drive_result res;
        if (req != ReqFixed && req != ReqDistance) begin
            held_drive   = '0;
            res.drive    = '0;
            res.at_speed = 1'b0;
            return res;
        end
        if (req == ReqFixed) begin
            target_q8 = longint'(target_rpm) * 256;
            band_q8   = longint'(band_fixed_rpm) * 256;
        end else begin
            inches    = longint'(dist_in) + longint'(trim) * TrimInches;
            target_q8 = longint'(DistSlopeQ8) * inches + longint'(DistOffsetQ8);
            band_q8   = longint'(band_dist_rpm) * 256;
        end
        err_q8 = target_q8 - longint'(meas) * 512;
        abs_err = (err_q8 < 0) ? -err_q8 : err_q8;
        res.at_speed = (abs_err < band_q8);

        // Proportional plus feedforward, both floor-shifted
        drv = ((longint'(kp_q24) * err_q8) >>> GainShift)
            + ((longint'(slope_q24) * target_q8) >>> GainShift)
            + longint'(offset_q15);

        // Clamp to the drive limit
        lim = longint'(limit_q15);
        if (drv > lim)
            drv = lim;
        else if (drv < -lim)
            drv = -lim;

        // Limit the change against the last drive
        step = longint'(slew_q15);
        if (drv - longint'(held_drive) > step)
            drv = longint'(held_drive) + step;
        else if (drv - longint'(held_drive) < -step)
            drv = longint'(held_drive) - step;

        held_drive = 16'(drv);
        res.drive  = 16'(drv);
        return res;
    endfunction

    function automatic void set_idling(input int sender_pct, input int receiver_pct);
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
    endfunction

    // Present one request, hold it until the transfer, then record its expected drive
    task automatic send_request(input logic [1:0] req, input logic signed [15:0] meas,
                                input logic [9:0] dist_in, input logic signed [4:0] trim);
        bit taken;
        taken = 1'b0;
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid     <= 1'b1;
        i_req_type     <= req;
        i_measured_rpm <= meas;
        i_distance_in  <= dist_in;
        i_trim_steps   <= trim;
        while (!taken) begin
            @(posedge i_clk);
            taken = !o_in_stall;
        end
        pending_drives.push_back(predict_drive(req, meas, dist_in, trim));
        items_sent++;
    endtask

    task automatic hold_input();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    // Stop sending and wait for every outstanding drive
    task automatic drain_results();
        hold_input();
        while (pending_drives.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [15:0] data);
        drain_results();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        apply_setting(index, data);
        reg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic write_reset_settings();
        write_reg(RegKpGain, KpGainReset);
        write_reg(RegTargetSpeed, 16'(TargetSpeedReset));
        write_reg(RegFfSlope, FfSlopeReset);
        write_reg(RegFfOffset, FfOffsetReset);
        write_reg(RegOutputLimit, 16'(OutputLimitReset));
        write_reg(RegSlewStep, 16'(SlewStepReset));
        write_reg(RegBandFixed, BandFixedReset);
        write_reg(RegBandDistance, BandDistanceReset);
    endtask

    // Mostly realistic gains and bands, with the full range now and then
    task automatic write_random_settings();
        write_reg(RegKpGain, ($urandom_range(3) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(3000)));
        write_reg(RegTargetSpeed, ($urandom_range(3) == 0) ? 16'($urandom)
                                                           : 16'($urandom_range(6000)));
        write_reg(RegFfSlope, ($urandom_range(3) == 0) ? 16'($urandom)
                                                       : 16'($urandom_range(4000)));
        write_reg(RegFfOffset, 16'($urandom));
        write_reg(RegOutputLimit, 16'($urandom));
        write_reg(RegSlewStep, ($urandom_range(1) == 0) ? 16'($urandom_range(3000))
                                                        : 16'($urandom));
        write_reg(RegBandFixed, ($urandom_range(3) == 0) ? 16'($urandom)
                                                         : 16'($urandom_range(600)));
        write_reg(RegBandDistance, ($urandom_range(3) == 0) ? 16'($urandom)
                                                            : 16'($urandom_range(600)));
    endtask

    // Random request, most of them with a speed near half the target
    task automatic send_random_request();
        int pick, half_rpm, meas_i;
        logic [1:0] req;
        logic [9:0] dist_in;
        logic signed [4:0] trim;
        logic signed [15:0] meas;
        pick = $urandom_range(99);
        dist_in = 10'($urandom);
        trim = 5'($urandom);
        if (pick < 4)
            req = ReqStop;
        else if (pick < 7)
            req = ReqUnused;
        else if (pick < 52)
            req = ReqFixed;
        else
            req = ReqDistance;
        if (req == ReqDistance)
            half_rpm = int'((longint'(DistSlopeQ8) * (longint'(dist_in)
                       + longint'(trim) * TrimInches) + longint'(DistOffsetQ8)) >>> 9);
        else
            half_rpm = int'(target_rpm) / 2;
        if ($urandom_range(99) < 60) begin
            meas_i = half_rpm + int'($urandom_range(400)) - 200;
            meas = 16'(meas_i);
        end else begin
            meas = 16'($urandom);
        end
        send_request(req, meas, dist_in, trim);
    endtask

    // Check each drive transfer against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_drives.size() == 0) begin
                $display("%0t: unexpected result: drive %0d at_speed %0b",
                         $time, o_drive, o_at_speed);
                mismatches++;
            end else begin
                oldest_drive = pending_drives.pop_front();
                if (o_drive !== oldest_drive.drive) begin
                    $display("%0t: drive mismatch: expected %0d actual %0d",
                             $time, oldest_drive.drive, o_drive);
                    mismatches++;
                end
                if (o_at_speed !== oldest_drive.at_speed) begin
                    $display("%0t: at_speed mismatch: expected %0b actual %0b",
                             $time, oldest_drive.at_speed, o_at_speed);
                    mismatches++;
                end
                results_checked++;
                if (oldest_drive.at_speed)
                    at_speed_hits++;
            end
        end
    end

    // End the run when no transfer happens for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QuietLimit) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("flywheel_velocity_controller_top regression: fail");
            $finish;
        end
    end

    // Reset settings: field extremes, both targets, stop and the unused code
    task automatic test_reset_defaults();
        send_request(ReqFixed, 16'sd1500, 10'd0, 5'sd0);
        send_request(ReqFixed, -16'sd32768, 10'd0, 5'sd0);
        send_request(ReqFixed, 16'sd32767, 10'd1023, -5'sd16);
        send_request(ReqDistance, 16'sd0, 10'd0, -5'sd16);
        send_request(ReqDistance, 16'sd32767, 10'd1023, 5'sd15);
        send_request(ReqDistance, 16'sd2292, 10'd100, 5'sd0);
        send_request(ReqStop, 16'sd1000, 10'd1023, 5'sd15);
        send_request(ReqUnused, -16'sd1000, 10'd512, -5'sd1);
        send_request(ReqFixed, 16'sd1495, 10'd0, 5'sd0);
    endtask

    // Error exactly on the band is not at speed; one step inside is
    task automatic test_band_edges();
        write_reg(RegBandFixed, 16'd10);
        send_request(ReqFixed, 16'sd1495, 10'd0, 5'sd0);
        send_request(ReqFixed, 16'sd1496, 10'd0, 5'sd0);
        send_request(ReqFixed, 16'sd1505, 10'd0, 5'sd0);
        send_request(ReqFixed, 16'sd1504, 10'd0, 5'sd0);
        write_reg(RegBandFixed, BandFixedReset);
    endtask

    // Zero gains so the offset alone sets the drive
    task automatic test_clamp_and_slew();
        write_reg(RegKpGain, 16'd0);
        write_reg(RegFfSlope, 16'd0);
        write_reg(RegOutputLimit, 16'd32767);
        write_reg(RegSlewStep, 16'd500);
        write_reg(RegFfOffset, 16'd500);
        send_request(ReqStop, 16'sd0, 10'd0, 5'sd0);
        // change of exactly one step is kept
        send_request(ReqFixed, 16'sd0, 10'd0, 5'sd0);
        // one over the step is cut back
        write_reg(RegFfOffset, 16'd1001);
        send_request(ReqFixed, 16'sd0, 10'd0, 5'sd0);
        // above the limit clamps, exactly on it is kept
        write_reg(RegOutputLimit, 16'd1000);
        send_request(ReqFixed, 16'sd0, 10'd0, 5'sd0);
        write_reg(RegFfOffset, 16'd1000);
        send_request(ReqFixed, 16'sd0, 10'd0, 5'sd0);
        // negative clamp followed by a slew-limited fall
        write_reg(RegFfOffset, 16'h8000);
        send_request(ReqFixed, 16'sd0, 10'd0, 5'sd0);
        send_request(ReqDistance, 16'sd0, 10'd0, 5'sd0);
        write_reset_settings();
    endtask

    // Every register at its top, then at its bottom
    task automatic test_register_extremes();
        int n;
        write_reg(RegKpGain, 16'hFFFF);
        write_reg(RegTargetSpeed, 16'hFFFF);
        write_reg(RegFfSlope, 16'hFFFF);
        write_reg(RegFfOffset, 16'h7FFF);
        write_reg(RegOutputLimit, 16'hFFFF);
        write_reg(RegSlewStep, 16'hFFFF);
        write_reg(RegBandFixed, 16'hFFFF);
        write_reg(RegBandDistance, 16'hFFFF);
        for (n = 0; n < 6; n++)
            send_random_request();
        write_reg(RegKpGain, 16'h0000);
        write_reg(RegTargetSpeed, 16'h0000);
        write_reg(RegFfSlope, 16'h0000);
        write_reg(RegFfOffset, 16'h8000);
        write_reg(RegOutputLimit, 16'h0000);
        write_reg(RegSlewStep, 16'h0000);
        write_reg(RegBandFixed, 16'h0000);
        write_reg(RegBandDistance, 16'h0000);
        for (n = 0; n < 6; n++)
            send_random_request();
        write_reset_settings();
    endtask

    // Bursts that let the block run completely dry in between
    task automatic test_drain_pause();
        int burst, n;
        for (burst = 0; burst < 4; burst++) begin
            for (n = 0; n < 10; n++)
                send_random_request();
            drain_results();
        end
    endtask

    // Random traffic under each idling mode with fresh settings per chunk
    task automatic test_random_traffic();
        int mode, chunk, n;
        for (mode = 0; mode < 3; mode++) begin
            case (mode)
                0:       set_idling(31, 48);
                1:       set_idling(48, 31);
                default: set_idling(0, 0);
            endcase
            for (chunk = 0; chunk < 4; chunk++) begin
                write_random_settings();
                for (n = 0; n < 125; n++)
                    send_random_request();
            end
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_req_type     = ReqFixed;
        i_measured_rpm = '0;
        i_distance_in  = '0;
        i_trim_steps   = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = RegKpGain;
        i_cfg_data     = '0;
        load_reset_settings();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_idling(31, 48);
        test_reset_defaults();
        test_band_edges();
        test_clamp_and_slew();
        test_register_extremes();
        test_drain_pause();
        test_random_traffic();

        // Let the last drives come out, then watch for strays
        drain_results();
        repeat (SettleCycles) @(posedge i_clk);

        $display("Sent %0d requests, checked %0d drives (%0d at speed), %0d register writes,",
                 items_sent, results_checked, at_speed_hits, reg_writes);
        $display("under sender/receiver idling of 31/48, 48/31 and none; %0d mismatches",
                 mismatches);
        if (mismatches == 0 && pending_drives.size() == 0)
            $display("flywheel_velocity_controller_top regression: pass");
        else
            $display("flywheel_velocity_controller_top regression: fail");
        $finish;
    end

endmodule

/* sim.f */
hdl/fvc_pkg.sv
hdl/flywheel_velocity_controller_top.sv
verif/tb.sv
